// ----- rtl/shs_pkg.sv -----
package shs_pkg;

   // block geometry and padding constants
   localparam int BLOCK_BYTES = 64;
   localparam int LEN_OFFSET  = 56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // pad byte selection codes
   localparam logic [1:0] PAD_MARK = 2'd0;
   localparam logic [1:0] PAD_ZERO = 2'd1;
   localparam logic [1:0] PAD_LEN  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic       take_byte;
      logic       pad_shift;
      logic [1:0] pad_sel;
      logic       round;
      logic       fold;
      logic       emit;
      logic       rearm;
   } shs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [5:0] pos;
      logic       round_last;
      logic       word_last;
   } shs_sts_type;

   // initial hash values
   function automatic logic [31:0] h_init(input logic [2:0] idx);
      logic [31:0] val;
      case (idx)
         3'd0: val = 32'h6a09e667;
         3'd1: val = 32'hbb67ae85;
         3'd2: val = 32'h3c6ef372;
         3'd3: val = 32'ha54ff53a;
         3'd4: val = 32'h510e527f;
         3'd5: val = 32'h9b05688c;
         3'd6: val = 32'h1f83d9ab;
         default: val = 32'h5be0cd19;
      endcase
      return val;
   endfunction

   // round constants
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] val;
      case (idx)
         6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
         6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
         6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
         6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
         6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
         6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
         6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
         6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
         6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
         6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
         6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
         6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
         6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
         6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
         6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
         6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
         6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
         6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
         6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
         6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
         6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
         6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
         6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
         6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
         6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
         6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
         6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
         6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
         6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
         6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
         6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
         6'd62: val = 32'hbef9a3f7;
         default: val = 32'hc67178f2;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/shs_datapath.sv -----
module shs_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  shs_pkg::shs_cmd_type      cmd,
   input  logic [7:0]                in_byte,
   output shs_pkg::shs_sts_type      sts,
   output logic [31:0]               digest_word,
   output logic [2:0]                word_index
);

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // message window: word 0 sits in the top bits, bytes shift in at the bottom
   logic [511:0] win_ff, win_in;
   logic [31:0]  work_ff [8];
   logic [31:0]  work_in [8];
   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic [31:0]  total_ff, total_in;
   logic [5:0]   pos_ff, pos_in;
   logic [5:0]   round_ff, round_in;
   logic [2:0]   idx_ff, idx_in;

   logic [63:0]  len_bits;
   logic [7:0]   len_byte;
   logic [7:0]   pad_byte;
   logic [7:0]   shift_byte;
   logic [31:0]  w0, w1, w9, w14;
   logic [31:0]  sig0, sig1, w_new;
   logic [31:0]  big0, big1, chv, majv, t1, t2;
   logic         shift_en;

   // padding byte source, length sent most significant byte first
   always_comb begin
      len_bits = {29'd0, total_ff, 3'd0};
      len_byte = len_bits[{~pos_ff[2:0], 3'b000} +: 8];
      case (cmd.pad_sel)
         shs_pkg::PAD_MARK: pad_byte = shs_pkg::PAD_BYTE;
         shs_pkg::PAD_LEN:  pad_byte = len_byte;
         default:           pad_byte = 8'd0;
      endcase
      shift_byte = cmd.take_byte ? in_byte : pad_byte;
      shift_en   = cmd.take_byte | cmd.pad_shift;
   end

   // message schedule over the sliding window
   always_comb begin
      w0    = win_ff[511:480];
      w1    = win_ff[479:448];
      w9    = win_ff[223:192];
      w14   = win_ff[63:32];
      sig0  = rotr32(w1, 7) ^ rotr32(w1, 18) ^ (w1 >> 3);
      sig1  = rotr32(w14, 17) ^ rotr32(w14, 19) ^ (w14 >> 10);
      w_new = w0 + sig0 + w9 + sig1;
   end

   // one compression round
   always_comb begin
      big1 = rotr32(work_ff[4], 6) ^ rotr32(work_ff[4], 11) ^ rotr32(work_ff[4], 25);
      chv  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1   = work_ff[7] + big1 + chv + shs_pkg::round_k(round_ff) + w0;
      big0 = rotr32(work_ff[0], 2) ^ rotr32(work_ff[0], 13) ^ rotr32(work_ff[0], 22);
      majv = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
           ^ (work_ff[1] & work_ff[2]);
      t2   = big0 + majv;
   end

   // next-state selection
   always_comb begin
      win_in   = win_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      if (shift_en) begin
         win_in   = {win_ff[503:0], shift_byte};
         work_in  = chain_ff;
         pos_in   = pos_ff + 6'd1;
         round_in = 6'd0;
      end
      if (cmd.take_byte) begin
         total_in = total_ff + 32'd1;
      end
      if (cmd.round) begin
         win_in     = {win_ff[479:0], w_new};
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         round_in   = round_ff + 6'd1;
      end
      if (cmd.fold) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = chain_ff[j] + work_ff[j];
         end
      end
      if (cmd.emit) begin
         idx_in = idx_ff + 3'd1;
      end
      if (cmd.rearm) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = shs_pkg::h_init(3'(j));
         end
         total_in = 32'd0;
         pos_in   = 6'd0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
   end

   // chaining words and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= shs_pkg::h_init(3'(j));
         end
         total_ff <= 32'd0;
         pos_ff   <= 6'd0;
         round_ff <= 6'd0;
         idx_ff   <= 3'd0;
      end else begin
         chain_ff <= chain_in;
         total_ff <= total_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   // status and result
   assign sts.pos        = pos_ff;
   assign sts.round_last = (round_ff == 6'(shs_pkg::BLOCK_BYTES - 1));
   assign sts.word_last  = (idx_ff == 3'd7);
   assign digest_word    = chain_ff[idx_ff];
   assign word_index     = idx_ff;

endmodule

// ----- rtl/shs_ctrl.sv -----
module shs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      has_byte,
   input  logic                      end_of_message,
   input  logic                      rsp_tready,
   input  shs_pkg::shs_sts_type      sts,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   output shs_pkg::shs_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FOLD  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [5:0] POS_LAST = 6'(shs_pkg::BLOCK_BYTES - 1);
   localparam logic [5:0] POS_LEN  = 6'(shs_pkg::LEN_OFFSET);

   logic [2:0] state_ff, state_in;
   logic       pad_active_ff, pad_active_in;
   logic       pad_first_ff, pad_first_in;
   logic       len_ok_ff, len_ok_in;
   logic       final_ff, final_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign accept     = req_tvalid & req_tready;

   // sequencing of bytes, padding, rounds and digest words
   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      len_ok_in     = len_ok_ff;
      final_in      = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_byte) begin
                  cmd.take_byte = 1'b1;
               end
               if (has_byte && sts.pos == POS_LAST) begin
                  state_in      = ST_ROUND;
                  pad_active_in = end_of_message;
                  pad_first_in  = end_of_message;
               end else if (end_of_message) begin
                  state_in      = ST_PAD;
                  pad_active_in = 1'b1;
                  pad_first_in  = 1'b1;
               end
            end
         end
         ST_PAD: begin
            cmd.pad_shift = 1'b1;
            if (pad_first_ff) begin
               cmd.pad_sel  = shs_pkg::PAD_MARK;
               pad_first_in = 1'b0;
               len_ok_in    = (sts.pos < POS_LEN);
            end else if (sts.pos >= POS_LEN && len_ok_ff) begin
               cmd.pad_sel = shs_pkg::PAD_LEN;
            end else begin
               cmd.pad_sel = shs_pkg::PAD_ZERO;
            end
            if (sts.pos == POS_LAST) begin
               state_in = ST_ROUND;
               final_in = (cmd.pad_sel == shs_pkg::PAD_LEN);
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!pad_active_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in  = ST_PAD;
               len_ok_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.emit = 1'b1;
               if (sts.word_last) begin
                  cmd.rearm     = 1'b1;
                  state_in      = ST_IDLE;
                  pad_active_in = 1'b0;
                  final_in      = 1'b0;
                  len_ok_in     = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         len_ok_ff     <= 1'b0;
         final_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         len_ok_ff     <= len_ok_in;
         final_ff      <= final_in;
      end
   end

   // fold follows the last round
   assert property (@(posedge clock) disable iff (reset)
      cmd.fold |-> $past(cmd.round && sts.round_last))
      else $error("fold without a completed round sequence");

   // digest is shown only after a block boundary
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (sts.pos == 6'd0))
      else $error("digest started mid-block");

   // length bytes only land in the length field
   assert property (@(posedge clock) disable iff (reset)
      (cmd.pad_shift && cmd.pad_sel == shs_pkg::PAD_LEN) |-> (sts.pos >= POS_LEN))
      else $error("length byte outside the length field");

   // digest follows a block that carried the length
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(final_ff))
      else $error("digest without a final block");

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// a byte transaction is taken only while idle; the byte that fills a 64-byte block starts
// a compression (rounds on the single round unit, then the chaining add), during which
// req_tready stays low and no new byte is taken
// end of message: padding shifts in one byte a cycle up to the block end, then one or
// two compressions, then eight digest words at one per cycle while rsp_tready is high
// reset: synchronous, loads the initial hash values and clears the counters, no sweep
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   shs_pkg::shs_cmd_type cmd;
   shs_pkg::shs_sts_type sts;

   // sequencing
   shs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .has_byte       (req_tuser),
      .end_of_message (req_tlast),
      .rsp_tready     (rsp_tready),
      .sts            (sts),
      .req_tready     (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .cmd            (cmd)
   );

   // message window, round unit and chaining words
   shs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_tdata),
      .sts         (sts),
      .digest_word (rsp_tdata),
      .word_index  (rsp_tuser)
   );

   assign rsp_tlast = &rsp_tuser;

endmodule
